// ===== rtl/sdspi_pkg.sv =====
// shared types, constants and helpers of the sd spi command engine
package sdspi_pkg;

	// engine phase
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ECHO    = 3'd1,
		PH_HUNT    = 3'd2,
		PH_COLLECT = 3'd3,
		PH_TAIL    = 3'd4
	} phase_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_LONG_LEN  = 2'd0,
		REG_BUSY_LEN  = 2'd1,
		REG_SHORT_LEN = 2'd2
	} reg_idx_t;

	localparam logic       OP_COMMAND   = 1'b0;
	localparam logic       OP_RECEIVE   = 1'b1;
	localparam logic [5:0] CMD_SEND_IF  = 6'd8;
	localparam logic [5:0] CMD_STOP     = 6'd12;
	localparam logic [5:0] CMD_READ_MUL = 6'd18;
	localparam logic [7:0] START_BITS   = 8'h40;
	localparam logic [7:0] DUMMY_BYTE   = 8'hFF;
	localparam logic [3:0] ECHO_BYTES   = 4'd7;
	localparam logic [2:0] CMD_RESULTS  = 3'd7;
	localparam logic [2:0] LAST_CMD_K   = 3'd6;

	// engine state
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  byte_count;
		logic [3:0]  response_length;
		logic [63:0] assembled_response;
		logic        multi_block_read;
	} state_t;

	// one input request
	typedef struct packed {
		logic        operation;
		logic [5:0]  command_index;
		logic [31:0] command_argument;
		logic [7:0]  command_crc;
		logic [7:0]  received_byte;
	} item_t;

	// one result
	typedef struct packed {
		logic        transmit_valid;
		logic [7:0]  transmit_byte;
		logic        select_hold;
		logic        select_auto;
		logic        response_valid;
		logic [63:0] response;
		logic        last;
	} result_t;

	// length register zero reads as one, above eight as eight
	function automatic logic [3:0] clamp_len(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v == 4'd0) r = 4'd1;
		else if (v > 4'd8) r = 4'd8;
		return r;
	endfunction

endpackage

// ===== rtl/sdspi_cmd_if.sv =====
// request channel carrying commands and received link bytes
interface sdspi_cmd_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [5:0]  command_index;
	logic [31:0] command_argument;
	logic [7:0]  command_crc;
	logic [7:0]  received_byte;

	modport source (output valid, operation, command_index, command_argument,
		command_crc, received_byte, input ready);
	modport sink (input valid, operation, command_index, command_argument,
		command_crc, received_byte, output ready);
endinterface

// ===== rtl/sdspi_rsp_if.sv =====
// result channel carrying transmit bytes, select control and responses
interface sdspi_rsp_if;
	logic        valid;
	logic        ready;
	logic        transmit_valid;
	logic [7:0]  transmit_byte;
	logic        select_hold;
	logic        select_auto;
	logic        response_valid;
	logic [63:0] response;
	logic        last;

	modport source (output valid, transmit_valid, transmit_byte, select_hold,
		select_auto, response_valid, response, last, input ready);
	modport sink (input valid, transmit_valid, transmit_byte, select_hold,
		select_auto, response_valid, response, last, output ready);
endinterface

// ===== rtl/sdspi_step.sv =====
// per-request decode: result count, k-th result and next engine state
module sdspi_step (
	input  sdspi_pkg::state_t  state,
	input  sdspi_pkg::item_t   item,
	input  logic [2:0]         k,
	input  logic [3:0]         long_len,
	input  logic [3:0]         busy_len,
	input  logic [3:0]         short_len,
	output logic [2:0]         nres,
	output sdspi_pkg::result_t res,
	output sdspi_pkg::state_t  nstate
);
	import sdspi_pkg::*;

	logic [3:0]  bc_inc;
	logic [63:0] asm_shift;
	logic        fin_hunt;
	logic        fin_collect;

	assign bc_inc      = state.byte_count + 4'd1;
	assign asm_shift   = {state.assembled_response[55:0], item.received_byte};
	assign fin_hunt    = (4'd1 >= state.response_length);
	assign fin_collect = (bc_inc >= state.response_length);

	// command framing, dummy byte or final result selection, and next engine state
	always_comb begin
		logic finishing;
		nres      = 3'd0;
		res       = '0;
		nstate    = state;
		finishing = 1'b0;
		if (item.operation == OP_COMMAND) begin
			if (state.phase == PH_IDLE) begin
				nres = CMD_RESULTS;
				if (item.command_index == CMD_SEND_IF)
					nstate.response_length = clamp_len(long_len);
				else if (item.command_index == CMD_STOP)
					nstate.response_length = clamp_len(busy_len);
				else
					nstate.response_length = clamp_len(short_len);
				nstate.multi_block_read   = (item.command_index == CMD_READ_MUL);
				nstate.byte_count         = 4'd0;
				nstate.assembled_response = '0;
				nstate.phase              = PH_ECHO;
				res.transmit_valid = 1'b1;
				res.last           = (k == LAST_CMD_K);
				unique case (k)
					3'd0: begin
						res.transmit_byte = DUMMY_BYTE;
						res.select_hold   = (item.command_index != CMD_STOP);
					end
					3'd1: res.transmit_byte = START_BITS | {2'b00, item.command_index};
					3'd2: res.transmit_byte = item.command_argument[31:24];
					3'd3: res.transmit_byte = item.command_argument[23:16];
					3'd4: res.transmit_byte = item.command_argument[15:8];
					3'd5: res.transmit_byte = item.command_argument[7:0];
					default: res.transmit_byte = item.command_crc;
				endcase
			end
		end else begin
			res.last = 1'b1;
			unique case (state.phase)
				PH_ECHO: begin
					if (bc_inc < ECHO_BYTES) begin
						nstate.byte_count = bc_inc;
					end else begin
						nstate.byte_count  = 4'd0;
						nstate.phase       = PH_HUNT;
						nres               = 3'd1;
						res.transmit_valid = 1'b1;
						res.transmit_byte  = DUMMY_BYTE;
					end
				end
				PH_HUNT: begin
					nres = 3'd1;
					if (item.received_byte[7]) begin
						res.transmit_valid = 1'b1;
						res.transmit_byte  = DUMMY_BYTE;
					end else begin
						nstate.assembled_response = {56'd0, item.received_byte};
						nstate.byte_count         = 4'd1;
						if (fin_hunt) begin
							finishing = 1'b1;
						end else begin
							nstate.phase       = PH_COLLECT;
							res.transmit_valid = 1'b1;
							res.transmit_byte  = DUMMY_BYTE;
						end
					end
				end
				PH_COLLECT: begin
					nres                      = 3'd1;
					nstate.assembled_response = asm_shift;
					nstate.byte_count         = bc_inc;
					if (fin_collect) begin
						finishing = 1'b1;
					end else begin
						res.transmit_valid = 1'b1;
						res.transmit_byte  = DUMMY_BYTE;
					end
				end
				PH_TAIL: nstate.phase = PH_IDLE;
				default: ;
			endcase
			// completed response, with the extra dummy for a multi-block read, else auto select
			if (finishing) begin
				res.response_valid = 1'b1;
				res.response       = nstate.assembled_response;
				if (state.multi_block_read) begin
					res.transmit_valid = 1'b1;
					res.transmit_byte  = DUMMY_BYTE;
					nstate.phase       = PH_TAIL;
				end else begin
					res.select_auto = 1'b1;
					nstate.phase    = PH_IDLE;
				end
			end
		end
	end

endmodule

// ===== rtl/sd_spi_command_engine.sv =====
// Top level: a command from idle yields 7 results (else none); a received byte yields 0 or 1.
// A request is held in the input register; its results are registered in the result register.
// Throughput: one received byte per cycle while rsp is not stalled; a command holds the input
// register until the single result register has taken its 7 results, one per unstalled cycle.
// Reset: arst_n clears the phase to idle, counters, response and valid flags; length
// registers reset to 5 (long), 1 (busy), 1 (short).
module sd_spi_command_engine (
	input  logic         clk,
	input  logic         arst_n,
	sdspi_cmd_if.sink    cmd,
	sdspi_rsp_if.source  rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import sdspi_pkg::*;

	logic [3:0] long_len_q;
	logic [3:0] busy_len_q;
	logic [3:0] short_len_q;
	reg_idx_t   reg_sel;
	logic       cfg_write;

	state_t     state_q;
	state_t     nstate;
	item_t      item_s1;
	logic       valid_s1;
	logic [2:0] k_q;
	logic [2:0] nres;
	result_t    res;
	result_t    out_q;
	logic       out_valid_q;

	logic       can_load;
	logic       emit;
	logic       done_s1;
	logic       accept;

	// configuration port
	assign pready    = 1'b1;
	assign reg_sel   = reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_len_q  <= 4'd5;
			busy_len_q  <= 4'd1;
			short_len_q <= 4'd1;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_LONG_LEN:  long_len_q  <= pwdata[3:0];
				REG_BUSY_LEN:  busy_len_q  <= pwdata[3:0];
				REG_SHORT_LEN: short_len_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_LONG_LEN:  prdata = {28'd0, long_len_q};
			REG_BUSY_LEN:  prdata = {28'd0, busy_len_q};
			REG_SHORT_LEN: prdata = {28'd0, short_len_q};
			default:       prdata = 32'd0;
		endcase
	end

	// decode of the held request
	sdspi_step u_step (
		.state     (state_q),
		.item      (item_s1),
		.k         (k_q),
		.long_len  (long_len_q),
		.busy_len  (busy_len_q),
		.short_len (short_len_q),
		.nres      (nres),
		.res       (res),
		.nstate    (nstate)
	);

	// handshake between input register and result register
	assign can_load  = !out_valid_q || rsp.ready;
	assign emit      = valid_s1 && (nres != 3'd0) && can_load;
	assign done_s1   = valid_s1 && ((nres == 3'd0) || (emit && res.last));
	assign cmd.ready = !valid_s1 || done_s1;
	assign accept    = cmd.valid && cmd.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.operation        <= cmd.operation;
			item_s1.command_index    <= cmd.command_index;
			item_s1.command_argument <= cmd.command_argument;
			item_s1.command_crc      <= cmd.command_crc;
			item_s1.received_byte    <= cmd.received_byte;
		end
	end

	// result index, advanced per result, and engine state, committed when the request retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= 3'd0;
			state_q <= '{phase: PH_IDLE, byte_count: 4'd0, response_length: 4'd0,
				assembled_response: 64'd0, multi_block_read: 1'b0};
		end else if (done_s1) begin
			k_q     <= 3'd0;
			state_q <= nstate;
		end else if (emit) begin
			k_q <= k_q + 3'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.transmit_valid = out_q.transmit_valid;
	assign rsp.transmit_byte  = out_q.transmit_byte;
	assign rsp.select_hold    = out_q.select_hold;
	assign rsp.select_auto    = out_q.select_auto;
	assign rsp.response_valid = out_q.response_valid;
	assign rsp.response       = out_q.response;
	assign rsp.last           = out_q.last;

	// a completed response always closes its request
	a_resp_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.response_valid |-> rsp.last)
		else $error("response result without last");

	// only a command request walks through several results
	a_multi_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != 3'd0 |-> valid_s1 && (item_s1.operation == OP_COMMAND))
		else $error("result index advanced for a received byte");

	// a command's results are emitted only from idle
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (item_s1.operation == OP_COMMAND) |-> state_q.phase == PH_IDLE)
		else $error("command framed while busy");

endmodule
